// File: sv/sgrp_pkg.sv
// ----------------------------------------------------------------------------
// SNMP GetResponse parser package
// Shared types, BER tag codes and parse-phase decode for the response parser.
// ----------------------------------------------------------------------------
package sgrp_pkg;

  localparam int unsigned LENGTH_WIDTH_DEF = 16;
  localparam int unsigned MAX_LEN_BYTES    = 7;

  // BER codes used by the walk.
  localparam logic [7:0] TAG_SEQUENCE  = 8'h30;
  localparam logic [7:0] TAG_INTEGER   = 8'h02;
  localparam logic [7:0] TAG_OCTETS    = 8'h04;
  localparam logic [7:0] TAG_GET_RESP  = 8'hA2;
  localparam logic [7:0] TAG_OID       = 8'h06;
  localparam logic [7:0] TAG_COUNTER32 = 8'h41;
  localparam logic [7:0] TAG_NONE      = 8'h00;

  typedef logic [4:0] phase_t;

  // Parse phases, in packet order.
  localparam phase_t PH_MSG_TAG  = 5'd0;
  localparam phase_t PH_MSG_LEN  = 5'd1;
  localparam phase_t PH_VER_TAG  = 5'd2;
  localparam phase_t PH_VER_LEN  = 5'd3;
  localparam phase_t PH_VER_BODY = 5'd4;
  localparam phase_t PH_COM_TAG  = 5'd5;
  localparam phase_t PH_COM_LEN  = 5'd6;
  localparam phase_t PH_COM_BODY = 5'd7;
  localparam phase_t PH_PDU_TAG  = 5'd8;
  localparam phase_t PH_PDU_LEN  = 5'd9;
  localparam phase_t PH_RID_TAG  = 5'd10;
  localparam phase_t PH_RID_LEN  = 5'd11;
  localparam phase_t PH_RID_BODY = 5'd12;
  localparam phase_t PH_ERR_TAG  = 5'd13;
  localparam phase_t PH_ERR_LEN  = 5'd14;
  localparam phase_t PH_ERR_BODY = 5'd15;
  localparam phase_t PH_EIX_TAG  = 5'd16;
  localparam phase_t PH_EIX_LEN  = 5'd17;
  localparam phase_t PH_EIX_BODY = 5'd18;
  localparam phase_t PH_VBL_TAG  = 5'd19;
  localparam phase_t PH_VBL_LEN  = 5'd20;
  localparam phase_t PH_VB_TAG   = 5'd21;
  localparam phase_t PH_VB_LEN   = 5'd22;
  localparam phase_t PH_OID_TAG  = 5'd23;
  localparam phase_t PH_OID_LEN  = 5'd24;
  localparam phase_t PH_OID_BODY = 5'd25;
  localparam phase_t PH_VAL_TAG  = 5'd26;
  localparam phase_t PH_VAL_LEN  = 5'd27;
  localparam phase_t PH_VAL_BODY = 5'd28;
  localparam phase_t PH_DONE     = 5'd29;

  typedef enum logic [2:0] {
    KIND_TAG,
    KIND_HDR_LEN,
    KIND_BODY_LEN,
    KIND_BODY,
    KIND_DONE
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FAIL  = 2'd1,
    ST_TRUNC = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eop;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] value;
    logic        is_counter;
  } res_t;

  function automatic kind_e phase_kind(input phase_t ph);
    kind_e k;
    case (ph) inside
      PH_MSG_TAG, PH_VER_TAG, PH_COM_TAG, PH_PDU_TAG, PH_RID_TAG, PH_ERR_TAG,
      PH_EIX_TAG, PH_VBL_TAG, PH_VB_TAG, PH_OID_TAG, PH_VAL_TAG:
        k = KIND_TAG;
      PH_MSG_LEN, PH_PDU_LEN, PH_VBL_LEN, PH_VB_LEN:
        k = KIND_HDR_LEN;
      PH_VER_LEN, PH_COM_LEN, PH_RID_LEN, PH_ERR_LEN, PH_EIX_LEN, PH_OID_LEN,
      PH_VAL_LEN:
        k = KIND_BODY_LEN;
      PH_VER_BODY, PH_COM_BODY, PH_RID_BODY, PH_ERR_BODY, PH_EIX_BODY,
      PH_OID_BODY, PH_VAL_BODY:
        k = KIND_BODY;
      default:
        k = KIND_DONE;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] phase_tag(input phase_t ph);
    logic [7:0] t;
    case (ph) inside
      PH_MSG_TAG, PH_VBL_TAG, PH_VB_TAG:                     t = TAG_SEQUENCE;
      PH_VER_TAG, PH_RID_TAG, PH_ERR_TAG, PH_EIX_TAG, PH_VAL_TAG: t = TAG_INTEGER;
      PH_COM_TAG:                                            t = TAG_OCTETS;
      PH_PDU_TAG:                                            t = TAG_GET_RESP;
      PH_OID_TAG:                                            t = TAG_OID;
      default:                                               t = TAG_NONE;
    endcase
    return t;
  endfunction

endpackage

// File: sv/sgrp_in_if.sv
// ----------------------------------------------------------------------------
// Byte stream interface
// Valid/ready channel that carries one received byte and its end mark.
// ----------------------------------------------------------------------------
interface sgrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

// File: sv/sgrp_out_if.sv
// ----------------------------------------------------------------------------
// Parse result interface
// Valid/ready channel that carries the status, value and type of a response.
// ----------------------------------------------------------------------------
interface sgrp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] value;
  logic        value_is_counter;

  modport source (output valid, output status, output value, output value_is_counter,
                  input ready);
  modport sink   (input valid, input status, input value, input value_is_counter,
                  output ready);
endinterface

// File: sv/snmp_get_response_parser.sv
// ----------------------------------------------------------------------------
// SNMP GetResponse parser
// Parses one SNMPv1 response datagram per packet and reports its value.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Word                                     Handshake
//   in_i     in   data_byte[7:0], end_of_packet            valid/ready
//   out_o    out  status[1:0], value[31:0], value_is_counter valid/ready
//
// One byte word is taken per clock while no final byte waits on the output
// side. A byte is held in the input register and then folded into the parser
// state; for the end-of-packet byte the result is loaded into the result
// register at the edge that folds that byte in, so a result word is offered
// once its final byte has passed through the input register.
// Throughput is set by the parser core step, one byte per cycle; a
// non-final byte never waits on the output side.
// A final byte waits in the input register only while an earlier result
// is still unclaimed, and in_i.ready then drops.
// Reset is asynchronous and active low; it empties both registers and
// returns the parser to the outer sequence tag. No clearing pass is needed.
//
// The walk follows the BER layout of a GetResponse: outer sequence,
// version (must be zero), community (skipped), PDU, request id, error
// status (must be zero), error index, varbind list, varbind, OID (skipped)
// and an INTEGER or Counter32 value, of which the low 32 bits are kept.
// Long-form lengths saturate at LENGTH_WIDTH bits. After a format failure
// the rest of the packet is ignored; a packet that ends before the value
// is complete is reported as truncated. Bytes after the value are ignored.
module snmp_get_response_parser #(
  parameter int unsigned LENGTH_WIDTH = sgrp_pkg::LENGTH_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sgrp_in_if.sink     in_i,
  sgrp_out_if.source  out_o
);
  import sgrp_pkg::*;

  logic  s1_valid;
  item_t s1_item;
  logic  out_free;
  logic  take;
  res_t  res;

  // A byte is consumed unless it closes a packet while a result still waits.
  assign take = s1_valid && (!s1_item.eop || out_free);

  sgrp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  sgrp_core #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (take),
    .item_i (s1_item),
    .res_o  (res)
  );

  sgrp_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (take && s1_item.eop),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule

// File: sv/sgrp_in_reg.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one byte word until the parser core consumes it.
// ----------------------------------------------------------------------------
module sgrp_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  sgrp_in_if.sink          in_i,
  input  logic             take_i,
  output logic             valid_o,
  output sgrp_pkg::item_t  item_o
);
  import sgrp_pkg::*;

  logic  valid_q;
  item_t item_q;

  // The register refills in the same cycle it is drained.
  assign in_i.ready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= '{data: in_i.data_byte, eop: in_i.end_of_packet};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: sv/sgrp_core.sv
// ----------------------------------------------------------------------------
// Parser core
// Walks the BER layout one byte per step and forms the result at packet end.
// ----------------------------------------------------------------------------
module sgrp_core #(
  parameter int unsigned LENGTH_WIDTH = sgrp_pkg::LENGTH_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  sgrp_pkg::item_t  item_i,
  output sgrp_pkg::res_t   res_o
);
  import sgrp_pkg::*;

  phase_t                  ph_q, ph_d;
  logic [2:0]              lbl_q, lbl_d;
  logic [LENGTH_WIDTH-1:0] lacc_q, lacc_d;
  logic [LENGTH_WIDTH-1:0] cnt_q, cnt_d;
  logic [31:0]             iacc_q, iacc_d;
  logic                    fail_q, fail_d;
  logic                    done_q, done_d;
  logic                    ctr_q, ctr_d;

  always_comb begin
    kind_e                   kind;
    logic                    len_fin;
    logic [LENGTH_WIDTH-1:0] len_val;
    logic [6:0]              long_n;
    logic [LENGTH_WIDTH-1:0] cnt_dec;

    ph_d    = ph_q;
    lbl_d   = lbl_q;
    lacc_d  = lacc_q;
    cnt_d   = cnt_q;
    iacc_d  = iacc_q;
    fail_d  = fail_q;
    ctr_d   = ctr_q;
    kind    = phase_kind(ph_q);
    len_fin = 1'b0;
    len_val = '0;
    long_n  = item_i.data[6:0];
    cnt_dec = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;

    if (step_i && !fail_q) begin
      case (kind)
        KIND_TAG: begin
          if (ph_q == PH_VAL_TAG && item_i.data == TAG_COUNTER32) begin
            ctr_d = 1'b1;
            ph_d  = phase_t'(ph_q + 5'd1);
          end else if (item_i.data == phase_tag(ph_q)) begin
            if (ph_q == PH_VAL_TAG) begin
              ctr_d = 1'b0;
            end
            ph_d = phase_t'(ph_q + 5'd1);
          end else begin
            fail_d = 1'b1;
          end
        end
        KIND_HDR_LEN, KIND_BODY_LEN: begin
          if (lbl_q == 3'd0) begin
            if (!item_i.data[7]) begin
              len_fin = 1'b1;
              len_val = LENGTH_WIDTH'(item_i.data);
            end else if (long_n == 7'd0) begin
              len_fin = 1'b1;
            end else if (long_n > 7'(MAX_LEN_BYTES)) begin
              fail_d = 1'b1;
            end else begin
              lbl_d  = long_n[2:0];
              lacc_d = '0;
            end
          end else begin
            // Saturate once another byte would push the length past its width.
            if (|lacc_q[LENGTH_WIDTH-1 -: 8]) begin
              lacc_d = '1;
            end else begin
              lacc_d = (lacc_q << 8) | LENGTH_WIDTH'(item_i.data);
            end
            lbl_d = lbl_q - 3'd1;
            if (lbl_q == 3'd1) begin
              len_fin = 1'b1;
              len_val = lacc_d;
            end
          end
        end
        KIND_BODY: begin
          if ((ph_q == PH_VER_BODY || ph_q == PH_ERR_BODY) && item_i.data != 8'd0) begin
            fail_d = 1'b1;
          end else begin
            if (ph_q == PH_VAL_BODY) begin
              iacc_d = {iacc_q[23:0], item_i.data};
            end
            cnt_d = cnt_dec;
            if (cnt_dec == '0) begin
              ph_d = phase_t'(ph_q + 5'd1);
            end
          end
        end
        default: begin
        end
      endcase

      if (len_fin) begin
        if (kind == KIND_HDR_LEN) begin
          ph_d = phase_t'(ph_q + 5'd1);
        end else begin
          if (ph_q == PH_VAL_LEN) begin
            iacc_d = '0;
          end
          cnt_d = len_val;
          // An empty field skips its contents phase.
          ph_d  = (len_val == '0) ? phase_t'(ph_q + 5'd2) : phase_t'(ph_q + 5'd1);
        end
      end
    end

    done_d = done_q || (ph_d == PH_DONE);

    if (fail_d) begin
      res_o = '{status: ST_FAIL, value: 32'd0, is_counter: 1'b0};
    end else if (done_d) begin
      res_o = '{status: ST_OK, value: iacc_d, is_counter: ctr_d};
    end else begin
      res_o = '{status: ST_TRUNC, value: 32'd0, is_counter: 1'b0};
    end

    // The last byte of a packet returns the parser to its starting state.
    if (step_i && item_i.eop) begin
      ph_d   = PH_MSG_TAG;
      lbl_d  = 3'd0;
      lacc_d = '0;
      cnt_d  = '0;
      iacc_d = '0;
      fail_d = 1'b0;
      done_d = 1'b0;
      ctr_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_MSG_TAG;
      lbl_q  <= 3'd0;
      lacc_q <= '0;
      cnt_q  <= '0;
      iacc_q <= '0;
      fail_q <= 1'b0;
      done_q <= 1'b0;
      ctr_q  <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      lbl_q  <= lbl_d;
      lacc_q <= lacc_d;
      cnt_q  <= cnt_d;
      iacc_q <= iacc_d;
      fail_q <= fail_d;
      done_q <= done_d;
      ctr_q  <= ctr_d;
    end
  end

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q <= PH_DONE)
    else $error("parse phase beyond the done phase");

  a_done_tracks_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q == (ph_q == PH_DONE))
    else $error("value-done flag out of step with the parse phase");

  a_eop_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.eop |=> ph_q == PH_MSG_TAG && !fail_q && !done_q)
    else $error("parser did not restart after the end of a packet");

  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fail_q && !(step_i && item_i.eop) |=> fail_q && $stable(ph_q))
    else $error("failure cleared or parsing went on before the end of a packet");

endmodule

// File: sv/sgrp_out_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one parse result until the sink takes it.
// ----------------------------------------------------------------------------
module sgrp_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  sgrp_pkg::res_t  res_i,
  output logic            free_o,
  sgrp_out_if.source      out_o
);
  import sgrp_pkg::*;

  logic valid_q;
  res_t res_q;

  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.status           = res_q.status;
  assign out_o.value            = res_q.value;
  assign out_o.value_is_counter = res_q.is_counter;

endmodule
